FILE: hdl/rvmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rvmd_pkg;

  localparam int unsigned XLEN    = 64;
  localparam int unsigned TAG_W   = 7;
  localparam int unsigned NCELLS  = XLEN;
  // operand register, chain of cells, result register
  localparam int unsigned LATENCY = NCELLS + 2;

  typedef enum logic [3:0] {
    CMD_MUL    = 4'd0,
    CMD_MULH   = 4'd1,
    CMD_MULHU  = 4'd2,
    CMD_MULHSU = 4'd3,
    CMD_MULW   = 4'd4,
    CMD_DIV    = 4'd5,
    CMD_DIVU   = 4'd6,
    CMD_REM    = 4'd7,
    CMD_REMU   = 4'd8,
    CMD_DIVW   = 4'd9,
    CMD_DIVUW  = 4'd10,
    CMD_REMW   = 4'd11,
    CMD_REMUW  = 4'd12
  } cmd_e;

  typedef enum logic [2:0] {
    SEL_ZERO = 3'd0,
    SEL_LO   = 3'd1,
    SEL_LOW  = 3'd2,
    SEL_HI   = 3'd3,
    SEL_QUOT = 3'd4,
    SEL_REM  = 3'd5
  } sel_e;

  typedef struct packed {
    logic [3:0]        cmd;
    logic              valid_op;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b_reg;
    logic signed [63:0] immediate;
    logic              use_reg_b;
    logic [TAG_W-1:0]  dest_tag;
  } req_t;

  typedef struct packed {
    logic              write_enable;
    logic [TAG_W-1:0]  result_tag;
    logic signed [63:0] result_value;
  } res_t;

  // working words handed from cell to cell
  typedef struct packed {
    logic             div;
    logic [XLEN-1:0]  x;   // product high half or partial remainder
    logic [XLEN-1:0]  y;   // multiplier / product low half or dividend / quotient
    logic [XLEN-1:0]  z;   // multiplicand or divisor
  } data_t;

  // sideband that rides along with each item
  typedef struct packed {
    logic             we;
    logic [TAG_W-1:0] tag;
    sel_e             sel;
    logic             word;
    logic             neg_q;
    logic             neg_r;
    logic             dz;
    logic [XLEN-1:0]  corr;
  } side_t;

  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
    sext32 = {{32{v[31]}}, v[31:0]};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rv64m_multiply_divide_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// rv64m multiply / divide unit
//
// input channel: req_i carries one item (command, operands, tag); it is taken
// at a rising edge with start_i high and busy_o low. busy_o is always low, so
// a new item may enter every cycle, independent items overlap in the chain.
// output channel: res_o holds a result for exactly one cycle, flagged by
// done_o; results leave in the order items came in and cannot be held off.
// an item passes one operand register, 64 cells and one result register on its
// way to done_o; throughput one item per cycle.
// the chain has 64 identical cells, each doing one shift-add multiply step
// or one restoring divide step, so latency is set by the 64-bit operand width.
// invalid items and tags at or above PHYS_REGS still give a result, with
// write_enable, tag and value all zero.
// reset clears every valid flag in the chain; items in flight are dropped.
module rv64m_multiply_divide_unit_core #(
  parameter int unsigned PHYS_REGS = 128
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire rvmd_pkg::req_t req_i,
  output logic                done_o,
  output rvmd_pkg::res_t      res_o
);

  localparam int unsigned XL = rvmd_pkg::XLEN;
  localparam int unsigned NC = rvmd_pkg::NCELLS;

  logic             accept;
  logic [XL-1:0]    a, b, an, bn, ma, mb;
  logic             word, sgn, sa, sb, we;
  rvmd_pkg::data_t  prep_d;
  rvmd_pkg::side_t  side_d;

  // chain links: index 0 is the operand register
  logic             vld   [NC+1];
  rvmd_pkg::data_t  data  [NC+1];
  rvmd_pkg::side_t  side  [NC+1];

  logic             vld_q;
  rvmd_pkg::data_t  data_q;
  rvmd_pkg::side_t  side_q;

  rvmd_pkg::res_t   res_d, res_q;
  logic             done_q;
  logic [XL-1:0]    quo, rmd, val;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // operand preparation
  always_comb begin
    a    = req_i.operand_a;
    b    = req_i.use_reg_b ? req_i.operand_b_reg : req_i.immediate;
    word = 1'b0;
    sgn  = 1'b0;
    unique case (req_i.cmd)
      rvmd_pkg::CMD_DIV,  rvmd_pkg::CMD_REM:   sgn = 1'b1;
      rvmd_pkg::CMD_DIVW, rvmd_pkg::CMD_REMW: begin
        sgn  = 1'b1;
        word = 1'b1;
      end
      rvmd_pkg::CMD_DIVUW, rvmd_pkg::CMD_REMUW: word = 1'b1;
      default: ;
    endcase
    // word forms narrow the operands first
    an = word ? (sgn ? rvmd_pkg::sext32(a) : {32'd0, a[31:0]}) : a;
    bn = word ? (sgn ? rvmd_pkg::sext32(b) : {32'd0, b[31:0]}) : b;
    sa = sgn && an[XL-1];
    sb = sgn && bn[XL-1];
    ma = sa ? (~an + 1'b1) : an;
    mb = sb ? (~bn + 1'b1) : bn;
    we = req_i.valid_op && (32'(req_i.dest_tag) < PHYS_REGS);

    side_d.we    = we;
    side_d.tag   = we ? req_i.dest_tag : '0;
    side_d.word  = word;
    side_d.neg_q = (sa ^ sb) && (bn != '0);
    side_d.neg_r = sa;
    side_d.dz    = (bn == '0);
    side_d.corr  = '0;
    side_d.sel   = rvmd_pkg::SEL_ZERO;

    prep_d.div = 1'b1;
    prep_d.x   = '0;
    prep_d.y   = ma;
    prep_d.z   = mb;

    unique case (req_i.cmd)
      rvmd_pkg::CMD_MUL:    side_d.sel = rvmd_pkg::SEL_LO;
      rvmd_pkg::CMD_MULW:   side_d.sel = rvmd_pkg::SEL_LOW;
      rvmd_pkg::CMD_MULHU:  side_d.sel = rvmd_pkg::SEL_HI;
      rvmd_pkg::CMD_MULH: begin
        side_d.sel  = rvmd_pkg::SEL_HI;
        side_d.corr = (a[XL-1] ? b : '0) + (b[XL-1] ? a : '0);
      end
      rvmd_pkg::CMD_MULHSU: begin
        side_d.sel  = rvmd_pkg::SEL_HI;
        side_d.corr = a[XL-1] ? b : '0;
      end
      rvmd_pkg::CMD_DIV, rvmd_pkg::CMD_DIVU,
      rvmd_pkg::CMD_DIVW, rvmd_pkg::CMD_DIVUW: side_d.sel = rvmd_pkg::SEL_QUOT;
      rvmd_pkg::CMD_REM, rvmd_pkg::CMD_REMU,
      rvmd_pkg::CMD_REMW, rvmd_pkg::CMD_REMUW: side_d.sel = rvmd_pkg::SEL_REM;
      default: ;
    endcase

    // multiplies run unsigned on the raw operands
    if (side_d.sel == rvmd_pkg::SEL_LO || side_d.sel == rvmd_pkg::SEL_LOW ||
        side_d.sel == rvmd_pkg::SEL_HI) begin
      prep_d.div = 1'b0;
      prep_d.y   = b;
      prep_d.z   = a;
    end
    if (!we) begin
      side_d.sel = rvmd_pkg::SEL_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= prep_d;
    side_q <= side_d;
  end

  assign vld[0]  = vld_q;
  assign data[0] = data_q;
  assign side[0] = side_q;

  // one multiply or divide bit per cell
  for (genvar i = 0; i < NC; i++) begin : g_cell
    rvmd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .data_i  (data[i]),
      .side_i  (side[i]),
      .valid_o (vld[i+1]),
      .data_o  (data[i+1]),
      .side_o  (side[i+1])
    );
  end

  // sign fix-up and result selection
  always_comb begin
    quo = side[NC].dz ? '1 :
          (side[NC].neg_q ? (~data[NC].y + 1'b1) : data[NC].y);
    rmd = side[NC].neg_r ? (~data[NC].x + 1'b1) : data[NC].x;
    case (side[NC].sel)
      rvmd_pkg::SEL_LO:   val = data[NC].y;
      rvmd_pkg::SEL_LOW:  val = rvmd_pkg::sext32(data[NC].y);
      rvmd_pkg::SEL_HI:   val = data[NC].x - side[NC].corr;
      rvmd_pkg::SEL_QUOT: val = side[NC].word ? rvmd_pkg::sext32(quo) : quo;
      rvmd_pkg::SEL_REM:  val = side[NC].word ? rvmd_pkg::sext32(rmd) : rmd;
      default:            val = '0;
    endcase
    res_d.write_enable = side[NC].we;
    res_d.result_tag   = side[NC].tag;
    res_d.result_value = val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: hdl/rvmd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rvmd_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire rvmd_pkg::data_t data_i,
  input  wire rvmd_pkg::side_t side_i,
  output logic                 valid_o,
  output rvmd_pkg::data_t      data_o,
  output rvmd_pkg::side_t      side_o
);

  logic            valid_q;
  rvmd_pkg::data_t data_d, data_q;
  rvmd_pkg::side_t side_q;

  logic [rvmd_pkg::XLEN:0] rem_t, div_d, sum_t, diff_t;
  logic                    ge;

  always_comb begin
    // restoring divide step
    rem_t  = {data_i.x, data_i.y[rvmd_pkg::XLEN-1]};
    div_d  = {1'b0, data_i.z};
    ge     = rem_t >= div_d;
    diff_t = rem_t - div_d;
    // shift-add multiply step
    sum_t = {1'b0, data_i.x} + (data_i.y[0] ? div_d : '0);
    data_d = data_i;
    if (data_i.div) begin
      data_d.x = ge ? diff_t[rvmd_pkg::XLEN-1:0] : rem_t[rvmd_pkg::XLEN-1:0];
      data_d.y = {data_i.y[rvmd_pkg::XLEN-2:0], ge};
    end else begin
      data_d.x = sum_t[rvmd_pkg::XLEN:1];
      data_d.y = {sum_t[0], data_i.y[rvmd_pkg::XLEN-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

FILE: hdl/rvmd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rvmd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire logic           busy_o,
  input wire logic           done_o,
  input wire rvmd_pkg::res_t res_o
);

  localparam int unsigned LAT = rvmd_pkg::LATENCY;

  // the unit never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

  // every accepted item comes out after a fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT done_o) else $error("result missing");

  // no result without an item accepted earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT)) else $error("spurious result");

  // a dropped item shows an all-zero result
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.write_enable |-> res_o.result_tag == '0 && res_o.result_value == '0)
    else $error("dropped item not zero");

endmodule

bind rv64m_multiply_divide_unit_core rvmd_checker u_rvmd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
`default_nettype wire

FILE: verif/rv64m_multiply_divide_unit_core_test.sv
`timescale 1ns / 1ps
module rv64m_multiply_divide_unit_core_test;

  localparam int unsigned PHYS_REGS   = 128;
  localparam int unsigned N_RANDOM    = 1280;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [63:0] MIN64       = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES64      = '1;

  // one row of the directed table: item plus an optional typed-in result
  typedef struct {
    rvmd_pkg::req_t req;
    bit             fixed;
    rvmd_pkg::res_t want;
  } corner_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  rvmd_pkg::req_t req_i;
  logic           done_o;
  rvmd_pkg::res_t res_o;

  rvmd_pkg::res_t pending_results[$];
  int unsigned    mismatches;
  int unsigned    idle_cycles;
  corner_row_t    corner_rows[$];

  rv64m_multiply_divide_unit_core #(
    .PHYS_REGS(PHYS_REGS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // signed quotient and remainder with the risc-v rules for zero and overflow
  function automatic logic [63:0] signed_quotient(input logic [63:0] a, input logic [63:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    sa = a;
    sb = b;
    if (b == '0) return ONES64;
    if (a == MIN64 && b == ONES64) return MIN64;
    return sa / sb;
  endfunction

  function automatic logic [63:0] signed_remainder(input logic [63:0] a, input logic [63:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    sa = a;
    sb = b;
    if (b == '0) return a;
    if (a == MIN64 && b == ONES64) return '0;
    return sa % sb;
  endfunction

  // full behavioural model of one item
  function automatic rvmd_pkg::res_t muldiv_result(input rvmd_pkg::req_t r);
    rvmd_pkg::res_t o;
    logic [63:0]    a, b, a_w, b_w, au_w, bu_w, v;
    logic [127:0]   p_ss, p_uu, p_su;
    o = '0;
    if (!r.valid_op || r.dest_tag >= PHYS_REGS) return o;
    a    = r.operand_a;
    b    = r.use_reg_b ? r.operand_b_reg : r.immediate;
    a_w  = {{32{a[31]}}, a[31:0]};
    b_w  = {{32{b[31]}}, b[31:0]};
    au_w = {32'h0, a[31:0]};
    bu_w = {32'h0, b[31:0]};
    // modular 128-bit products of the extended operands
    p_ss = {{64{a[63]}}, a} * {{64{b[63]}}, b};
    p_uu = {64'h0, a} * {64'h0, b};
    p_su = {{64{a[63]}}, a} * {64'h0, b};
    case (r.cmd)
      rvmd_pkg::CMD_MUL:    v = p_uu[63:0];
      rvmd_pkg::CMD_MULH:   v = p_ss[127:64];
      rvmd_pkg::CMD_MULHU:  v = p_uu[127:64];
      rvmd_pkg::CMD_MULHSU: v = p_su[127:64];
      rvmd_pkg::CMD_MULW:   v = {{32{p_uu[31]}}, p_uu[31:0]};
      rvmd_pkg::CMD_DIV:    v = signed_quotient(a, b);
      rvmd_pkg::CMD_DIVU:   v = (b == '0) ? ONES64 : a / b;
      rvmd_pkg::CMD_REM:    v = signed_remainder(a, b);
      rvmd_pkg::CMD_REMU:   v = (b == '0) ? a : a % b;
      rvmd_pkg::CMD_DIVW:   v = signed_quotient(a_w, b_w);
      rvmd_pkg::CMD_DIVUW:  v = (bu_w == '0) ? ONES64 : au_w / bu_w;
      rvmd_pkg::CMD_REMW:   v = signed_remainder(a_w, b_w);
      rvmd_pkg::CMD_REMUW:  v = (bu_w == '0) ? au_w : au_w % bu_w;
      default:              v = '0;
    endcase
    o.write_enable = 1'b1;
    o.result_tag   = r.dest_tag;
    o.result_value = {{32{v[31]}}, v[31:0]};
    // only the w forms narrow the result
    if (!(r.cmd inside {rvmd_pkg::CMD_MULW, rvmd_pkg::CMD_DIVW, rvmd_pkg::CMD_DIVUW,
                        rvmd_pkg::CMD_REMW, rvmd_pkg::CMD_REMUW})) begin
      o.result_value = v;
    end
    return o;
  endfunction

  function automatic rvmd_pkg::req_t make_item(input logic [3:0] cmd, input logic valid_op,
                                               input logic [63:0] a, input logic [63:0] b_reg,
                                               input logic [63:0] imm, input logic use_reg,
                                               input logic [6:0] tag);
    rvmd_pkg::req_t r;
    r.cmd           = cmd;
    r.valid_op      = valid_op;
    r.operand_a     = a;
    r.operand_b_reg = b_reg;
    r.immediate     = imm;
    r.use_reg_b     = use_reg;
    r.dest_tag      = tag;
    return r;
  endfunction

  // operand with a bias towards the interesting values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONES64;
      2:       return MIN64;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return {32'h0, 32'h8000_0000};
      5:       return {$urandom, 32'h0};
      6:       return {{32{1'b1}}, $urandom};
      7:       return 64'($urandom_range(0, 40)) - 64'd20;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_row(input rvmd_pkg::req_t r, input bit fixed, input logic [63:0] value);
    corner_row_t row;
    row.req                = r;
    row.fixed              = fixed;
    row.want.write_enable  = r.valid_op;
    row.want.result_tag    = r.valid_op ? r.dest_tag : '0;
    row.want.result_value  = value;
    corner_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input rvmd_pkg::res_t want,
                                 input rvmd_pkg::res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected we=%0b tag=%0d value=%h, got we=%0b tag=%0d value=%h",
               what, want.write_enable, want.result_tag, want.result_value,
               got.write_enable, got.result_tag, got.result_value);
    end
  endtask

  // result checker, sampled at the edge that ends the strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("no item outstanding", '0, res_o);
      end else begin
        rvmd_pkg::res_t want;
        want = pending_results.pop_front();
        if (res_o.write_enable !== want.write_enable ||
            res_o.result_tag !== want.result_tag ||
            res_o.result_value !== want.result_value) begin
          report_mismatch("field", want, res_o);
        end
      end
    end
  end

  // watchdog: cycles with neither an item taken nor a result returned
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rv64m_multiply_divide_unit_core_test failed");
        $finish;
      end
    end
  end

  // present one item and hold it until taken, then queue its expectation
  task automatic send_item(input rvmd_pkg::req_t r, input bit fixed,
                           input rvmd_pkg::res_t want);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (!(start_i && !busy_o));
    pending_results.push_back(fixed ? want : muldiv_result(r));
  endtask

  // random gap before the next item; none inside the quiet stretch
  task automatic maybe_gap(input int unsigned idx);
    int unsigned gap;
    gap = 0;
    if ((idx < 400 || idx > 700) && $urandom_range(0, 99) < 10) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    rvmd_pkg::req_t r;
    mismatches  = 0;
    idle_cycles = 0;
    start_i     = 1'b0;
    req_i       = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: typed-in results where they are obvious
    add_row(make_item(rvmd_pkg::CMD_MUL, 1'b1, ONES64, ONES64, '0, 1'b1, 7'd1), 1'b1, 64'd1);
    add_row(make_item(rvmd_pkg::CMD_MULH, 1'b1, MIN64, MIN64, '0, 1'b1, 7'd2), 1'b1,
            64'h4000_0000_0000_0000);
    add_row(make_item(rvmd_pkg::CMD_MULHU, 1'b1, ONES64, ONES64, '0, 1'b1, 7'd3), 1'b1,
            64'hFFFF_FFFF_FFFF_FFFE);
    add_row(make_item(rvmd_pkg::CMD_MULHSU, 1'b1, ONES64, ONES64, '0, 1'b1, 7'd4), 1'b1,
            ONES64);
    add_row(make_item(rvmd_pkg::CMD_MULW, 1'b1, 64'h1_0000_FFFF, 64'h1_0001_0000, '0, 1'b1,
                      7'd5), 1'b0, '0);
    // divide by zero
    add_row(make_item(rvmd_pkg::CMD_DIV, 1'b1, 64'd77, '0, ONES64, 1'b1, 7'd6), 1'b1, ONES64);
    add_row(make_item(rvmd_pkg::CMD_DIVU, 1'b1, 64'd77, '0, '0, 1'b1, 7'd7), 1'b1, ONES64);
    add_row(make_item(rvmd_pkg::CMD_REM, 1'b1, MIN64, '0, '0, 1'b1, 7'd8), 1'b1, MIN64);
    add_row(make_item(rvmd_pkg::CMD_REMU, 1'b1, ONES64, '0, '0, 1'b1, 7'd9), 1'b1, ONES64);
    add_row(make_item(rvmd_pkg::CMD_DIVW, 1'b1, 64'd5, 64'hFFFF_FFFF_0000_0000, '0, 1'b1,
                      7'd10), 1'b1, ONES64);
    add_row(make_item(rvmd_pkg::CMD_DIVUW, 1'b1, 64'd5, 64'h1_0000_0000, '0, 1'b1, 7'd11),
            1'b1, ONES64);
    add_row(make_item(rvmd_pkg::CMD_REMW, 1'b1, 64'h1234_5678_8000_0001, '0, '0, 1'b1,
                      7'd12), 1'b1, 64'hFFFF_FFFF_8000_0001);
    add_row(make_item(rvmd_pkg::CMD_REMUW, 1'b1, 64'h0000_0001_7FFF_FFFF, '0, '0, 1'b1,
                      7'd13), 1'b1, 64'h0000_0000_7FFF_FFFF);
    // signed overflow
    add_row(make_item(rvmd_pkg::CMD_DIV, 1'b1, MIN64, ONES64, '0, 1'b1, 7'd14), 1'b1, MIN64);
    add_row(make_item(rvmd_pkg::CMD_REM, 1'b1, MIN64, ONES64, '0, 1'b1, 7'd15), 1'b1, '0);
    add_row(make_item(rvmd_pkg::CMD_DIVW, 1'b1, 64'h8000_0000, 64'h0_FFFF_FFFF, '0, 1'b1,
                      7'd16), 1'b1, 64'hFFFF_FFFF_8000_0000);
    add_row(make_item(rvmd_pkg::CMD_REMW, 1'b1, 64'h8000_0000, ONES64, '0, 1'b1, 7'd17), 1'b1,
            '0);
    // immediate as second operand, signed divide with mixed signs
    add_row(make_item(rvmd_pkg::CMD_DIV, 1'b1, -64'sd7, ONES64, 64'd2, 1'b0, 7'd18), 1'b1,
            -64'sd3);
    add_row(make_item(rvmd_pkg::CMD_REM, 1'b1, -64'sd7, '0, 64'd2, 1'b0, 7'd19), 1'b1,
            -64'sd1);
    // invalid item returns all zero, unused selector returns zero value
    add_row(make_item(rvmd_pkg::CMD_MUL, 1'b0, 64'd3, 64'd3, '0, 1'b1, 7'd127), 1'b1, '0);
    add_row(make_item(4'd13, 1'b1, 64'd3, 64'd3, '0, 1'b1, 7'd127), 1'b1, '0);
    add_row(make_item(4'd15, 1'b1, ONES64, ONES64, ONES64, 1'b0, 7'd0), 1'b1, '0);
    add_row(make_item(rvmd_pkg::CMD_DIVU, 1'b1, ONES64, 64'd1, '0, 1'b1, 7'd64), 1'b1, ONES64);

    foreach (corner_rows[i]) begin
      send_item(corner_rows[i].req, corner_rows[i].fixed, corner_rows[i].want);
      maybe_gap(i);
    end

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      r.cmd           = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                    : 4'($urandom_range(0, 12));
      r.valid_op      = ($urandom_range(0, 9) != 0);
      r.operand_a     = pick_operand();
      r.operand_b_reg = pick_operand();
      r.immediate     = pick_operand();
      r.use_reg_b     = 1'($urandom_range(0, 1));
      r.dest_tag      = 7'($urandom);
      send_item(r, 1'b0, '0);
      maybe_gap(i);
    end
    start_i <= 1'b0;

    // drain the pipeline, then allow a margin for stray strobes
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (rvmd_pkg::LATENCY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("rv64m_multiply_divide_unit_core_test passed");
    end else begin
      $display("rv64m_multiply_divide_unit_core_test failed");
    end
    $finish;
  end

endmodule
